### rtl/plf_pkg.sv
`default_nettype none

package plf_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int IDX_W      = 4;   // point_index
    localparam int SEG_W      = 4;   // segment_count register
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Request kinds (tuser on the input stream)
    localparam logic REQ_EVAL  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PASS_THROUGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_OF_SERVICE = 2'd2;

    // Status of the serial multiply/divide unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

`default_nettype wire

### rtl/plf_ram.sv
`default_nettype none

module plf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/plf_muldiv.sv
`default_nettype none

// round(dx * dy / span), ties away from zero; needs dx < span.
// One multiplier bit per cycle, then one quotient bit per cycle, in one
// shared shift register.
module plf_muldiv
    import plf_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dx,
    input  wire logic [WIDTH-1:0] i_dy,
    input  wire logic [WIDTH-1:0] i_span,
    output t_md_stat              o_stat,
    output logic      [WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(WIDTH);

    typedef enum logic [4:0] {
        P_IDLE  = 5'b00001,
        P_MUL   = 5'b00010,
        P_DIV   = 5'b00100,
        P_ROUND = 5'b01000,
        P_DONE  = 5'b10000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [2*WIDTH-1:0] r_prod,  n_prod;
    logic [WIDTH-1:0]   r_mcand, n_mcand;
    logic [WIDTH-1:0]   r_span,  n_span;
    logic [WIDTH-1:0]   r_quot,  n_quot;
    logic [CW-1:0]      r_step,  n_step;

    logic [WIDTH-1:0] hi;
    logic [WIDTH:0]   mul_sum;
    logic [WIDTH:0]   shifted;
    logic [WIDTH+1:0] trial;
    logic             ge;
    logic [WIDTH-1:0] rem_next;
    logic             round_up;
    logic             step_last;

    assign hi        = r_prod[2*WIDTH-1:WIDTH];
    assign mul_sum   = {1'b0, hi} + (r_prod[0] ? {1'b0, r_mcand} : {(WIDTH+1){1'b0}});
    assign shifted   = {hi, r_prod[WIDTH-1]};
    assign trial     = {1'b0, shifted} - {2'b00, r_span};
    assign ge        = ~trial[WIDTH+1];
    assign rem_next  = ge ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
    assign round_up  = ({hi, 1'b0} >= {1'b0, r_span});
    assign step_last = (r_step == '0);

    always_comb begin
        n_phase = r_phase;
        n_prod  = r_prod;
        n_mcand = r_mcand;
        n_span  = r_span;
        n_quot  = r_quot;
        n_step  = r_step;
        unique case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_prod  = {{WIDTH{1'b0}}, i_dx};
                    n_mcand = i_dy;
                    n_span  = i_span;
                    n_step  = CW'(WIDTH - 1);
                    n_phase = P_MUL;
                end
            end
            P_MUL: begin
                // shift-add: product grows into the upper half
                n_prod = {mul_sum, r_prod[WIDTH-1:1]};
                n_step = r_step - 1'b1;
                if (step_last) begin
                    n_step  = CW'(WIDTH - 1);
                    n_phase = P_DIV;
                end
            end
            P_DIV: begin
                // restoring division: remainder high, quotient bits shift in low
                n_prod = {rem_next, r_prod[WIDTH-2:0], ge};
                n_step = r_step - 1'b1;
                if (step_last) begin
                    n_phase = P_ROUND;
                end
            end
            P_ROUND: begin
                n_quot  = r_prod[WIDTH-1:0] + WIDTH'(round_up);
                n_phase = P_DONE;
            end
            P_DONE: begin
                n_phase = P_IDLE;
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_mcand <= n_mcand;
        r_span  <= n_span;
        r_quot  <= n_quot;
        r_step  <= n_step;
    end

    assign o_stat.busy = (r_phase != P_IDLE);
    assign o_stat.done = (r_phase == P_DONE);
    assign o_quot      = r_quot;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_phase == P_IDLE))
        else $error("muldiv started while busy");

    a_rem_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == P_DIV) |-> (hi < r_span))
        else $error("division remainder not below divisor");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> !o_stat.done)
        else $error("done held longer than one cycle");

endmodule

`default_nettype wire

### rtl/piecewise_linear_function.sv
`default_nettype none

// Piecewise-linear function generator. Write transfers (tuser = 1) load
// breakpoint (x, y) pairs into a small table; evaluate transfers (tuser = 0)
// map a signed fixed-point sample through the curve and return one result
// with a bad flag; writes return nothing. Below the first breakpoint the
// output is y[0], at or above breakpoint segment_count it is y[segment_count],
// otherwise it is interpolated in the first segment [x[n], x[n+1]) holding the
// sample, rounded to nearest with ties away from zero. Out of service returns
// the last output with bad set; pass-through or a zero segment count copies
// the sample. A breakpoint must be written before any evaluation reads it;
// the table has no reset. An evaluate with no table lookup goes through
// S_RESULT to the output register; one that clamps at an end also passes
// S_FIRST and, at the top, S_LAST; an interpolation passes S_FIRST, S_LAST,
// S_SCAN and S_MULDIV, whose serial unit forms the product one bit per cycle
// and then divides one quotient bit per cycle. If no segment holds the
// sample, the last output is returned. One evaluate is in flight at a time;
// the input is ready again as soon as the result moves to the output register.
module piecewise_linear_function
    import plf_pkg::*;
#(
    parameter int NUM_POINTS  = 15,
    parameter int VALUE_WIDTH = 32,
    localparam int IN_TDATA_W  = ((IDX_W + 3 * VALUE_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write port
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // point_index, point_x, point_y, sample
    input  wire logic [0:0]             s_axis_tuser,  // req_type
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // value
    output logic      [0:0]             m_axis_tuser   // bad
);

    localparam int VW       = VALUE_WIDTH;
    localparam int AW       = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int LAST_IDX = NUM_POINTS - 1;
    localparam int X_LSB    = IDX_W;
    localparam int Y_LSB    = IDX_W + VW;
    localparam int S_LSB    = IDX_W + 2 * VW;
    // flipping the sign bit turns two's complement into offset binary
    localparam logic [VW-1:0] SIGN_BIT = {1'b1, {(VW-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LAST   = 6'b000010,   // compare with last used breakpoint
        S_FIRST  = 6'b000100,   // compare with breakpoint 0
        S_SCAN   = 6'b001000,   // walk segments upward
        S_MULDIV = 6'b010000,   // serial interpolation
        S_RESULT = 6'b100000    // hand result to output register
    } t_state;

    // configuration
    logic [SEG_W-1:0] r_seg_count, n_seg_count;
    logic             r_pass,      n_pass;
    logic             r_oos,       n_oos;

    // control
    t_state           r_state,     n_state;
    logic             r_out_valid, n_out_valid;
    logic [VW-1:0]    r_last,      n_last;      // last output, two's complement

    // payload
    logic [VW-1:0]    r_bx,        n_bx;        // sample, offset binary
    logic [VW-1:0]    r_px,        n_px;        // previous breakpoint, offset binary
    logic [VW-1:0]    r_py,        n_py;
    logic [VW-1:0]    r_y0,        n_y0;
    logic             r_neg,       n_neg;
    logic [AW-1:0]    r_cnt,       n_cnt;
    logic [VW-1:0]    r_res_value, n_res_value;
    logic             r_res_bad,   n_res_bad;
    logic [VW-1:0]    r_out_value, n_out_value;
    logic             r_out_bad,   n_out_bad;

    // stream fields
    logic             in_xfer;
    logic [IDX_W-1:0] in_idx;
    logic [VW-1:0]    in_x;
    logic [VW-1:0]    in_y;
    logic [VW-1:0]    in_sample;

    // breakpoint table
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [2*VW-1:0]  ram_rdata;
    logic [VW-1:0]    cur_x;
    logic [VW-1:0]    cur_y;
    logic [VW-1:0]    cur_y_raw;
    logic [AW-1:0]    seg_sat;

    // interpolation unit
    logic             md_start;
    logic [VW-1:0]    md_dx;
    logic [VW-1:0]    md_dy;
    logic [VW-1:0]    md_span;
    t_md_stat         md_stat;
    logic [VW-1:0]    md_quot;
    logic [VW-1:0]    interp_b;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign in_idx    = s_axis_tdata[IDX_W-1:0];
    assign in_x      = s_axis_tdata[X_LSB +: VW];
    assign in_y      = s_axis_tdata[Y_LSB +: VW];
    assign in_sample = s_axis_tdata[S_LSB +: VW];

    assign ram_we    = in_xfer && (s_axis_tuser[0] == REQ_WRITE)
                       && (int'(in_idx) < NUM_POINTS);
    assign ram_waddr = AW'(in_idx);

    assign cur_x     = ram_rdata[VW-1:0] ^ SIGN_BIT;
    assign cur_y_raw = ram_rdata[2*VW-1:VW];
    assign cur_y     = cur_y_raw ^ SIGN_BIT;

    // segment count clamps to the last table entry
    assign seg_sat = (int'(r_seg_count) > LAST_IDX) ? AW'(LAST_IDX) : AW'(r_seg_count);

    // interpolation operands, all offset binary so differences are magnitudes
    assign md_dx    = r_bx - r_px;
    assign md_span  = cur_x - r_px;
    assign md_dy    = (cur_y >= r_py) ? (cur_y - r_py) : (r_py - cur_y);
    assign interp_b = r_neg ? (r_y0 - md_quot) : (r_y0 + md_quot);

    plf_ram #(
        .WIDTH (2 * VW),
        .DEPTH (NUM_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({in_y, in_x}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    plf_muldiv #(
        .WIDTH (VW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_dx    (md_dx),
        .i_dy    (md_dy),
        .i_span  (md_span),
        .o_stat  (md_stat),
        .o_quot  (md_quot)
    );

    // configuration writes
    always_comb begin
        n_seg_count = r_seg_count;
        n_pass      = r_pass;
        n_oos       = r_oos;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEG_COUNT:      n_seg_count = i_cfg_data[SEG_W-1:0];
                CFG_PASS_THROUGH:   n_pass      = i_cfg_data[0];
                CFG_OUT_OF_SERVICE: n_oos       = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer: breakpoint 0 is checked before the last used one, so a
    // sample below x[0] yields y[0] even when the table is not ascending
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_bx        = r_bx;
        n_px        = r_px;
        n_py        = r_py;
        n_y0        = r_y0;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_res_value = r_res_value;
        n_res_bad   = r_res_bad;
        ram_raddr   = '0;
        md_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (s_axis_tuser[0] == REQ_EVAL)) begin
                    n_res_bad = 1'b0;
                    if (r_oos) begin
                        n_res_value = r_last;
                        n_res_bad   = 1'b1;
                        n_state     = S_RESULT;
                    end else if (r_pass || (seg_sat == '0)) begin
                        n_res_value = in_sample;
                        n_last      = in_sample;
                        n_state     = S_RESULT;
                    end else begin
                        n_bx      = in_sample ^ SIGN_BIT;
                        ram_raddr = '0;
                        n_state   = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                if (r_bx < cur_x) begin
                    n_res_value = cur_y_raw;
                    n_last      = cur_y_raw;
                    n_state     = S_RESULT;
                end else begin
                    n_px      = cur_x;
                    n_py      = cur_y;
                    ram_raddr = seg_sat;
                    n_state   = S_LAST;
                end
            end
            S_LAST: begin
                if (r_bx >= cur_x) begin
                    n_res_value = cur_y_raw;
                    n_last      = cur_y_raw;
                    n_state     = S_RESULT;
                end else begin
                    n_cnt     = AW'(1);
                    ram_raddr = AW'(1);
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_bx >= r_px) && (r_bx < cur_x)) begin
                    md_start = 1'b1;
                    n_neg    = (cur_y < r_py);
                    n_y0     = r_py;
                    n_state  = S_MULDIV;
                end else if (r_cnt == seg_sat) begin
                    // x values not ascending: no segment holds the sample
                    n_res_value = r_last;
                    n_state     = S_RESULT;
                end else begin
                    n_px      = cur_x;
                    n_py      = cur_y;
                    n_cnt     = r_cnt + 1'b1;
                    ram_raddr = r_cnt + 1'b1;
                end
            end
            S_MULDIV: begin
                if (md_stat.done) begin
                    n_res_value = interp_b ^ SIGN_BIT;
                    n_last      = interp_b ^ SIGN_BIT;
                    n_state     = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_bad   = r_out_bad;
        priority if ((r_state == S_RESULT) && (!r_out_valid || m_axis_tready)) begin
            n_out_valid = 1'b1;
            n_out_value = r_res_value;
            n_out_bad   = r_res_bad;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last      <= '0;
            r_seg_count <= '0;
            r_pass      <= 1'b0;
            r_oos       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
            r_seg_count <= n_seg_count;
            r_pass      <= n_pass;
            r_oos       <= n_oos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bx        <= n_bx;
        r_px        <= n_px;
        r_py        <= n_py;
        r_y0        <= n_y0;
        r_neg       <= n_neg;
        r_cnt       <= n_cnt;
        r_res_value <= n_res_value;
        r_res_bad   <= n_res_bad;
        r_out_value <= n_out_value;
        r_out_bad   <= n_out_bad;
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = OUT_TDATA_W'(r_out_value);
    assign m_axis_tuser[0] = r_out_bad;

    a_muldiv_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULDIV) |-> md_stat.busy)
        else $error("waiting on idle interpolation unit");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_cnt != '0) && (r_cnt <= seg_sat)))
        else $error("segment scan index out of range");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RESULT) && (!r_out_valid || m_axis_tready)) |=> r_out_valid)
        else $error("result not moved to output register");

    a_bad_only_oos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> r_oos)
        else $error("bad result while in service");

endmodule

`default_nettype wire
